[rtl/core/rbd_pkg.sv]
// Shared types and constants for the byte-wise rANS decoder.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    // Field widths fixed by the stream format.
    localparam int FREQ_W  = 13;
    localparam int STATE_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;    // idle, input side may hand over a word
        logic capture;  // latch the input word
        logic exec;     // carry out the captured item
        logic scan;     // table scan in progress
        logic mul;      // form freq * (state >> precision)
        logic upd;      // finish the state update of a decode
        logic emit;     // move the result into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_decode;  // the captured item needs a symbol decode
        logic scan_done;  // the entry under compare ends the scan
        logic out_free;   // the output register can take a result
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/core/rbd_ctrl.sv]
// Controller state machine of the rANS decoder.
`timescale 1ns / 1ps
`default_nettype none

module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = i_status.go_decode ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.ready   = (r_state == ST_IDLE);
        o_cmd.capture = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.exec    = (r_state == ST_EXEC);
        o_cmd.scan    = (r_state == ST_SCAN);
        o_cmd.mul     = (r_state == ST_MUL);
        o_cmd.upd     = (r_state == ST_UPD);
        o_cmd.emit    = (r_state == ST_EMIT) && i_status.out_free;
    end

endmodule

`default_nettype wire

[rtl/core/rbd_datapath.sv]
// Datapath of the rANS decoder: tables, coder state, scan and output register.
`timescale 1ns / 1ps
`default_nettype none

module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int NUM_SYMBOLS      = 256,
    parameter int PROB_PRECISION   = 12,
    parameter int LOWER_BOUND_BITS = 23
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_ctrl_cmd              i_cmd,
    output t_dp_status             o_status,
    input  wire [IN_DATA_W-1:0]    i_s_tdata,
    input  wire [IN_USER_W-1:0]    i_s_tuser,
    input  wire                    i_cfg_we,
    input  wire [STATE_W-1:0]      i_cfg_wdata,
    input  wire                    i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_DATA_W-1:0]  o_m_tdata,
    output logic [OUT_USER_W-1:0]  o_m_tuser
);

    localparam int AW     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int SHR_W  = STATE_W - PROB_PRECISION;
    localparam int PROD_W = FREQ_W + SHR_W;
    localparam int CMP_W  = 17;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SYMBOLS - 1);

    // Captured input word.
    logic [1:0]        r_in_action;
    logic [7:0]        r_in_idx;
    logic [FREQ_W-1:0] r_in_freq;
    logic [7:0]        r_in_byte;
    logic              r_in_present;

    // Architectural state.
    logic [STATE_W-1:0] r_symbol_count;
    logic [FREQ_W-1:0]  r_running_sum;
    logic [STATE_W-1:0] r_coder;
    logic [2:0]         r_init_cnt;
    logic               r_renorm;
    logic [STATE_W-1:0] r_left;

    // Frequency/cumulative table: one row holds {freq, cum}.
    logic [2*FREQ_W-1:0]    r_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_vld;
    logic [2*FREQ_W-1:0]    r_rd_data;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    logic [AW-1:0]          rd_addr;

    // Decode working registers.
    logic [PROB_PRECISION-1:0] r_slot;
    logic [7:0]                r_hit_sym;
    logic [FREQ_W-1:0]         r_hit_freq;
    logic [FREQ_W-1:0]         r_hit_cum;
    logic [PROD_W-1:0]         r_prod;

    // Result of the item in flight and the output register.
    logic [7:0] r_res_sym;
    logic       r_res_valid;
    logic       r_res_taken;
    logic       r_res_fin;
    logic       r_res_err;
    logic       r_out_valid;
    logic [7:0] r_out_sym;
    logic       r_out_sv;
    logic       r_out_taken;
    logic       r_out_fin;
    logic       r_out_err;

    logic              load_ok;
    logic [AW-1:0]     load_addr;
    logic [FREQ_W-1:0] load_cum;
    logic              init_done;
    logic              below_bound;
    logic              renorm_take;
    logic [FREQ_W-1:0] ent_freq;
    logic [FREQ_W-1:0] ent_cum;
    logic              hit;

    assign load_ok     = ({1'b0, r_in_idx} < 9'(NUM_SYMBOLS));
    assign load_addr   = r_in_idx[AW-1:0];
    assign load_cum    = (r_in_idx == 8'd0) ? '0 : r_running_sum;
    assign init_done   = r_init_cnt[2];
    assign below_bound = (r_coder[STATE_W-1:LOWER_BOUND_BITS] == '0);
    assign renorm_take = r_renorm && below_bound && r_in_present;

    assign o_status.go_decode = (r_in_action == ACT_STEP) && init_done
                                && !renorm_take && (r_left != '0);

    // Table entry under compare; a row never written reads as zero.
    assign ent_freq = r_rd_vld ? r_rd_data[2*FREQ_W-1:FREQ_W] : '0;
    assign ent_cum  = r_rd_vld ? r_rd_data[FREQ_W-1:0] : '0;
    assign hit = (CMP_W'(ent_cum) <= CMP_W'(r_slot))
                 && (CMP_W'(r_slot) < (CMP_W'(ent_cum) + CMP_W'(ent_freq)));

    // The scan runs from the top symbol down, so the first match is the
    // highest one; symbol 0 ends it either way.
    assign o_status.scan_done = hit || (r_rd_idx == '0);
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign rd_addr = i_cmd.exec ? LAST_IDX : (r_rd_idx - AW'(1));

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_in_action == ACT_LOAD) && load_ok) begin
            r_mem[load_addr] <= {r_in_freq, load_cum};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.exec && (r_in_action == ACT_LOAD) && load_ok) begin
                r_vld[load_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
        if (i_cmd.capture) begin
            r_in_action  <= i_s_tuser;
            r_in_idx     <= i_s_tdata[7:0];
            r_in_freq    <= i_s_tdata[20:8];
            r_in_byte    <= i_s_tdata[28:21];
            r_in_present <= i_s_tdata[29];
        end
        if (i_cmd.exec) begin
            r_slot <= r_coder[PROB_PRECISION-1:0];
        end
        if (i_cmd.scan && o_status.scan_done) begin
            r_hit_sym  <= 8'(r_rd_idx);
            r_hit_freq <= ent_freq;
            r_hit_cum  <= ent_cum;
        end
        if (i_cmd.mul) begin
            r_prod <= r_hit_freq * r_coder[STATE_W-1:PROB_PRECISION];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= '0;
            r_running_sum  <= '0;
            r_coder        <= '0;
            r_init_cnt     <= '0;
            r_renorm       <= 1'b0;
            r_left         <= '0;
            r_res_sym      <= '0;
            r_res_valid    <= 1'b0;
            r_res_taken    <= 1'b0;
            r_res_fin      <= 1'b0;
            r_res_err      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_symbol_count <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_res_sym   <= '0;
                r_res_valid <= 1'b0;
                r_res_taken <= 1'b0;
                r_res_fin   <= 1'b0;
                r_res_err   <= 1'b0;
                unique case (r_in_action)
                    ACT_LOAD: begin
                        if (load_ok) begin
                            if (r_in_idx == 8'd0) begin
                                r_running_sum <= r_in_freq;
                            end else begin
                                r_running_sum <= r_running_sum + r_in_freq;
                            end
                        end
                    end
                    ACT_START: begin
                        r_left     <= r_symbol_count;
                        r_coder    <= '0;
                        r_init_cnt <= '0;
                        r_renorm   <= 1'b0;
                    end
                    ACT_STEP: begin
                        if (!init_done) begin
                            if (r_in_present) begin
                                r_coder     <= {r_coder[STATE_W-9:0], r_in_byte};
                                r_init_cnt  <= r_init_cnt + 3'd1;
                                r_res_taken <= 1'b1;
                            end else begin
                                r_res_err <= 1'b1;
                            end
                        end else if (renorm_take) begin
                            r_coder     <= {r_coder[STATE_W-9:0], r_in_byte};
                            r_res_taken <= 1'b1;
                            r_res_fin   <= (r_left == '0);
                        end else begin
                            r_renorm  <= 1'b0;
                            // Finished is set here when nothing is left; a decode sets it at its update.
                            r_res_fin <= (r_left == '0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.upd) begin
                r_coder     <= STATE_W'(r_prod) + STATE_W'(r_slot)
                               - STATE_W'(r_hit_cum);
                r_left      <= r_left - STATE_W'(1);
                r_renorm    <= (r_left != STATE_W'(1));
                r_res_sym   <= r_hit_sym;
                r_res_valid <= 1'b1;
                r_res_fin   <= (r_left == STATE_W'(1));
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sym   <= r_res_sym;
            r_out_sv    <= r_res_valid;
            r_out_taken <= r_res_taken;
            r_out_fin   <= r_res_fin;
            r_out_err   <= r_res_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_err, r_out_fin, r_out_taken, r_out_sym};
    assign o_m_tuser  = r_out_sv;

endmodule

`default_nettype wire

[rtl/core/rans_byte_decoder.sv]
// Top level of the byte-wise rANS decoder with a table-scan symbol search.
`timescale 1ns / 1ps
`default_nettype none

// This block decodes a byte-wise rANS stream one word at a time. Load words
// write the symbol frequencies in ascending order and build the cumulative
// starts from a running sum; a start word arms the decode of symbol_count
// symbols; each step word takes an initial state byte, takes a
// renormalization byte, or decodes one symbol. Every input word yields
// exactly one output word. The block works on one word at a time: any word
// that decodes no symbol (a load, a start, an undefined action, or a step
// that takes a byte, reports a missing byte or finds nothing left) passes
// through capture, execute and hand-off to the output register. A step
// that decodes a symbol adds a table search after execute, because the
// frequency table is a memory with one registered read port, scanned from
// the highest symbol downward, one entry per cycle, until the first slot
// that holds the state's low bits (or symbol 0). The search is followed by
// a multiply step and an add step for the state update. After reset the
// table reads as all zero through per-entry valid bits, so no clearing
// pass is needed. The output register lets a finished word wait for the
// sink while the block goes back to accept the next input word.
module rans_byte_decoder
    import rbd_pkg::*;
#(
    parameter int NUM_SYMBOLS      = 256,
    parameter int PROB_PRECISION   = 12,
    parameter int LOWER_BOUND_BITS = 23
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Input stream.
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // [7:0] symbol_index, [20:8] frequency, [28:21] data_byte,
    // [29] byte_present, [31:30] zero
    input  wire [IN_DATA_W-1:0]    i_s_tdata,
    // [1:0] action
    input  wire [IN_USER_W-1:0]    i_s_tuser,
    // Output stream.
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // [7:0] symbol, [8] byte_taken, [9] finished, [10] error_code,
    // [15:11] zero
    output logic [OUT_DATA_W-1:0]  o_m_tdata,
    // [0] symbol_valid
    output logic [OUT_USER_W-1:0]  o_m_tuser,
    // symbol_count register write.
    input  wire                    i_cfg_we,
    input  wire [STATE_W-1:0]      i_cfg_wdata
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    rbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rbd_datapath #(
        .NUM_SYMBOLS      (NUM_SYMBOLS),
        .PROB_PRECISION   (PROB_PRECISION),
        .LOWER_BOUND_BITS (LOWER_BOUND_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // The input side is open only while the controller is idle.
    assign o_s_tready = cmd.ready;

endmodule

`default_nettype wire

[verif/rans_byte_decoder_tb.sv]
// Self-checking testbench for the byte-wise rANS decoder, with a built-in predictor.
`timescale 1ns / 1ps

// The testbench drives load, start, step and undefined words into the
// decoder and runs a predictor of the decoder next to it. On every input
// handshake the predictor works out the single output word that this input
// word must produce and queues it. A checker compares each output handshake,
// field by field, with the oldest queued word.
//
// The run has these parts:
//  - steps before any start, a missing initial byte and an undefined action;
//  - a decode against the all-zero table, where no slot holds the state;
//  - table extremes: an oversized frequency, a 13-bit wrap of the running
//    sum, overlapping slots and the largest symbol_count;
//  - random streams on small tables, mostly well formed with random bytes,
//    with noise words, restarts, exhaustion and broken tables mixed in;
//  - a full 256-entry table at the end, so that stale upper entries do not
//    disturb the small-table streams.
// symbol_count is only written while nothing is in flight. Every input word
// yields one output word, so an empty queue means the decoder is idle.
module rans_byte_decoder_tb;
    import rbd_pkg::*;

    localparam int PREC        = 12;
    localparam int BOUND_BITS  = 23;
    localparam int SYM_COUNT   = 256;
    localparam logic [31:0] LOWER_BOUND = 32'd1 << BOUND_BITS;
    // The one action code that the package leaves unused.
    localparam logic [1:0] ACT_UNDEF = 2'd3;
    localparam int RANDOM_WORDS = 1150;
    // Quiet cycles allowed before the run is declared hung. The slowest
    // correct word is a full table scan, plus a long sink stall and a long
    // sender gap.
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  idx;
        logic [12:0] freq;
        logic [7:0]  data;
        logic        present;
    } t_word;

    typedef struct packed {
        logic [7:0] symbol;
        logic       sym_valid;
        logic       taken;
        logic       finished;
        logic       err;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [STATE_W-1:0]    i_cfg_wdata = '0;

    rans_byte_decoder #(
        .NUM_SYMBOLS(SYM_COUNT),
        .PROB_PRECISION(PREC),
        .LOWER_BOUND_BITS(BOUND_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Predictor copy of the decoder state and of the symbol_count register.
    logic [12:0] freq_mem [SYM_COUNT];
    logic [12:0] cum_mem [SYM_COUNT];
    logic [12:0] mass_sum;
    logic [31:0] coder_x;
    logic [2:0]  init_cnt;
    logic        renorm_armed;
    logic [31:0] left_cnt;
    logic [31:0] count_reg;

    t_outcome outcome_fifo [$];
    t_outcome last_outcome;

    int  fail_count = 0;
    int  words_sent = 0;
    int  n_symbols = 0;
    int  n_taken = 0;
    int  n_missing = 0;
    int  n_settings = 0;
    int  quiet_cycles = 0;
    bit  no_gaps = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out the output word for one accepted input word and advances
    // the predictor state the same way the decoder must.
    task automatic predict_outcome(input t_word w, output t_outcome o);
        int          hit;
        int          hi;
        logic [31:0] slot;
        logic        do_decode;
        o = '0;
        case (w.act)
            ACT_LOAD: begin
                freq_mem[w.idx] = w.freq;
                if (w.idx == 8'd0) begin
                    cum_mem[0] = '0;
                    mass_sum = w.freq;
                end else begin
                    cum_mem[w.idx] = mass_sum;
                    mass_sum = mass_sum + w.freq;  // wraps at 13 bits
                end
            end
            ACT_START: begin
                left_cnt = count_reg;
                coder_x = '0;
                init_cnt = '0;
                renorm_armed = 1'b0;
            end
            ACT_STEP: begin
                if (init_cnt < 3'd4) begin
                    // Still collecting the big-endian initial state.
                    if (w.present) begin
                        coder_x = {coder_x[23:0], w.data};
                        init_cnt = init_cnt + 3'd1;
                        o.taken = 1'b1;
                    end else begin
                        o.err = 1'b1;
                    end
                end else begin
                    do_decode = 1'b1;
                    if (renorm_armed) begin
                        if (coder_x < LOWER_BOUND && w.present) begin
                            coder_x = {coder_x[23:0], w.data};
                            o.taken = 1'b1;
                            do_decode = 1'b0;
                        end else begin
                            // Renormalization ends and the decode happens
                            // in this same step.
                            renorm_armed = 1'b0;
                        end
                    end
                    if (do_decode && left_cnt != 0) begin
                        slot = coder_x & ((32'd1 << PREC) - 32'd1);
                        // The highest symbol whose slot holds the value wins;
                        // with no such slot, symbol 0 is used.
                        hit = 0;
                        for (int s = 0; s < SYM_COUNT; s++) begin
                            hi = int'(cum_mem[s]) + int'(freq_mem[s]);
                            if (int'(cum_mem[s]) <= int'(slot) && int'(slot) < hi)
                                hit = s;
                        end
                        coder_x = 32'(freq_mem[hit]) * (coder_x >> PREC) + slot
                                  - 32'(cum_mem[hit]);
                        o.symbol = 8'(hit);
                        o.sym_valid = 1'b1;
                        left_cnt = left_cnt - 32'd1;
                        renorm_armed = (left_cnt != 0);
                    end
                    o.finished = (left_cnt == 0);
                end
            end
            default: ;  // the undefined action leaves everything alone
        endcase
        n_symbols += o.sym_valid;
        n_taken += o.taken;
        n_missing += o.err;
    endtask

    // Sender gaps: mostly none or short, a few long, none at all in
    // stretches where no_gaps is set.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic t_word random_word(input logic [1:0] act);
        t_word w;
        w.act = act;
        w.idx = 8'($urandom_range(0, 255));
        w.freq = 13'($urandom_range(0, 8191));
        w.data = 8'($urandom_range(0, 255));
        w.present = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic t_word step_word(input logic [7:0] b, input logic present);
        t_word w;
        w = random_word(ACT_STEP);
        w.data = b;
        w.present = present;
        return w;
    endfunction

    function automatic t_word load_word(input logic [7:0] idx, input logic [12:0] freq);
        t_word w;
        w = random_word(ACT_LOAD);
        w.idx = idx;
        w.freq = freq;
        return w;
    endfunction

    // Sends one input word. tvalid stays high after the handshake so that a
    // following word goes out back to back; whoever lets time pass without
    // sending lowers it first.
    task automatic send_word(input t_word w);
        int       gap;
        t_outcome o;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {2'b00, w.present, w.data, w.freq, w.idx};
        i_s_tuser <= w.act;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_outcome(w, o);
        outcome_fifo.push_back(o);
        last_outcome = o;
        words_sent++;
    endtask

    // Holds the sender off until every queued output word has come out.
    task automatic wait_drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (outcome_fifo.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_symbol_count(input logic [31:0] value);
        wait_drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        count_reg = value;
        n_settings++;
    endtask

    // Loads symbols 0 .. entries-1 in ascending order. A well-formed table
    // sums to 2^PREC; a broken one takes random, sometimes oversized values.
    task automatic load_freq_table(input int entries, input bit well_formed);
        int mass_left;
        int cap;
        int f;
        mass_left = 1 << PREC;
        cap = 2 * (1 << PREC) / entries;
        for (int i = 0; i < entries; i++) begin
            if (!well_formed) begin
                f = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, cap);
            end else if (i == entries - 1) begin
                f = mass_left;
            end else begin
                f = $urandom_range(0, (mass_left < cap) ? mass_left : cap);
                mass_left -= f;
            end
            send_word(load_word(8'(i), 13'(f)));
        end
    endtask

    // One stream: arm count symbols, then step until the decoder reports
    // finished and a few steps beyond. A byte that was not taken is offered
    // again. Noisy streams mix in undefined words, stray loads, restarts,
    // missing bytes and sometimes a stream that runs dry for good.
    task automatic run_stream(input logic [31:0] count, input bit noisy);
        logic [7:0] offer;
        logic       present;
        int         steps;
        int         tail;
        int         step_cap;
        int         dry_at;
        int         r;
        set_symbol_count(count);
        send_word(random_word(ACT_START));
        offer = 8'($urandom_range(0, 255));
        steps = 0;
        tail = -1;
        step_cap = 8 * int'(count) + 40;
        dry_at = (noisy && $urandom_range(0, 4) == 0)
                 ? $urandom_range(6, 6 + 2 * int'(count)) : -1;
        while (steps < step_cap && tail != 0) begin
            r = noisy ? $urandom_range(0, 99) : 99;
            if (r < 2) begin
                send_word(random_word(ACT_UNDEF));
            end else if (r < 3) begin
                send_word(random_word(ACT_LOAD));
            end else if (r < 4) begin
                send_word(random_word(ACT_START));
            end else begin
                present = !(r < 9 || (dry_at >= 0 && steps >= dry_at));
                send_word(step_word(offer, present));
                steps++;
                if (last_outcome.taken)
                    offer = 8'($urandom_range(0, 255));
                if (tail > 0)
                    tail--;
                else if (tail < 0 && last_outcome.finished)
                    tail = $urandom_range(0, 2);
            end
        end
    endtask

    // Steps before any start behave as a start with a count of zero; a
    // missing initial byte is an error; the undefined action does nothing.
    task automatic test_before_start();
        send_word(step_word(8'h5A, 1'b0));
        send_word(random_word(ACT_UNDEF));
        send_word(step_word(8'hFF, 1'b1));
        send_word(step_word(8'h00, 1'b1));
        send_word(step_word(8'h80, 1'b1));
        send_word(step_word(8'h01, 1'b1));
        send_word(step_word(8'hC3, 1'b1));
    endtask

    // With the reset table every frequency is zero, so no slot holds the
    // state and symbol 0 is decoded. The steps then exercise a renormalization
    // byte and a renormalization ended by a missing byte.
    task automatic test_empty_table();
        set_symbol_count(32'd3);
        send_word(random_word(ACT_START));
        send_word(step_word(8'h12, 1'b1));
        send_word(step_word(8'h34, 1'b1));
        send_word(step_word(8'h56, 1'b1));
        send_word(step_word(8'h78, 1'b1));
        send_word(step_word(8'h9A, 1'b1));
        send_word(step_word(8'hAB, 1'b1));
        send_word(step_word(8'hCD, 1'b0));
        send_word(step_word(8'hEF, 1'b1));
    endtask

    // An oversized frequency at symbol 0, a running sum that wraps at 13
    // bits, and symbol 2 overlapping symbol 0 at one slot. The largest
    // symbol_count keeps the stream from ever finishing.
    task automatic test_table_extremes();
        send_word(load_word(8'd0, 13'h1FFF));
        send_word(load_word(8'd1, 13'd4096));
        send_word(load_word(8'd2, 13'd4096));
        set_symbol_count(32'hFFFF_FFFF);
        send_word(random_word(ACT_START));
        send_word(step_word(8'hFF, 1'b1));
        send_word(step_word(8'hFF, 1'b1));
        send_word(step_word(8'hFF, 1'b1));
        send_word(step_word(8'hFF, 1'b1));
        send_word(step_word(8'h00, 1'b1));
        send_word(step_word(8'h00, 1'b1));
    endtask

    // Random streams on small tables. Most tables are well formed with 16
    // entries; some are shorter, leaving stale entries above, and some are
    // broken. One stream in four runs with no sender gaps.
    task automatic test_random_streams();
        int       first_word;
        int       r;
        logic [31:0] count;
        first_word = words_sent;
        load_freq_table(16, 1'b1);
        while (words_sent - first_word < RANDOM_WORDS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                load_freq_table(($urandom_range(0, 3) == 0) ? $urandom_range(2, 15) : 16,
                                $urandom_range(0, 99) < 85);
            end
            r = $urandom_range(0, 99);
            count = (r < 10) ? 32'd0 : (r < 20) ? 32'd1 : 32'($urandom_range(2, 40));
            run_stream(count, $urandom_range(0, 3) != 0);
        end
        no_gaps = 1'b0;
    endtask

    // Every symbol index loaded once, then a clean stream on that table.
    task automatic test_full_table();
        load_freq_table(SYM_COUNT, 1'b1);
        run_stream(32'd80, 1'b0);
    endtask

    // Sink pacing: short stalls, a few long ones, and stretches with no
    // stall at all. One assignment per falling edge.
    initial begin : sink_pacing
        int   run;
        int   roll;
        logic level;
        forever begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                level = 1'b1;
                run = $urandom_range(50, 200);
            end else if (roll < 55) begin
                level = 1'b1;
                run = $urandom_range(1, 6);
            end else if (roll < 93) begin
                level = 1'b0;
                run = $urandom_range(1, 3);
            end else begin
                level = 1'b0;
                run = $urandom_range(10, 60);
            end
            repeat (run) begin
                @(negedge i_clk);
                i_m_tready <= level;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Output checker: each output word against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (outcome_fifo.size() == 0) begin
                $display("%0t ns: output word with none expected, expected nothing, got %h/%h",
                         $time, o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                want = outcome_fifo.pop_front();
                check_field("symbol", want.symbol, o_m_tdata[7:0]);
                check_field("symbol_valid", want.sym_valid, o_m_tuser[0]);
                check_field("byte_taken", want.taken, o_m_tdata[8]);
                check_field("finished", want.finished, o_m_tdata[9]);
                check_field("error_code", want.err, o_m_tdata[10]);
            end
        end
    end

    // Watchdog: counts cycles in which neither side hands over a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, outcome_fifo.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < SYM_COUNT; s++) begin
            freq_mem[s] = '0;
            cum_mem[s] = '0;
        end
        mass_sum = '0;
        coder_x = '0;
        init_cnt = '0;
        renorm_armed = 1'b0;
        left_cnt = '0;
        count_reg = '0;
        last_outcome = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_before_start();
        test_empty_table();
        test_table_extremes();
        test_random_streams();
        test_full_table();

        wait_drain();
        repeat (30) @(posedge i_clk);

        $display("Run covered %0d words: %0d decoded symbols, %0d bytes taken, %0d missing bytes.",
                 words_sent, n_symbols, n_taken, n_missing);
        $display("symbol_count was set %0d times; %0d field mismatches seen.",
                 n_settings, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rbd_pkg.sv
rtl/core/rbd_ctrl.sv
rtl/core/rbd_datapath.sv
rtl/core/rans_byte_decoder.sv
verif/rans_byte_decoder_tb.sv
